// ----- hdl/mtcp_pkg.sv -----
// Package for the MIDI track chunk parser: payload structs, parse phases and codes.
// No dependencies.
package mtcp_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_byte;
    logic        out_byte_valid;
    logic [1:0]  event_kind;
    logic [27:0] delta_ticks;
    logic        last;
  } out_item_t;

  typedef enum logic [10:0] {
    PH_LEN        = 11'b00000000001,
    PH_DELTA      = 11'b00000000010,
    PH_TYPE       = 11'b00000000100,
    PH_CHAN       = 11'b00000001000,
    PH_META_TYPE  = 11'b00000010000,
    PH_META_LEN   = 11'b00000100000,
    PH_META_DATA  = 11'b00001000000,
    PH_SYSEX_LEN  = 11'b00010000000,
    PH_SYSEX_DATA = 11'b00100000000,
    PH_DONE       = 11'b01000000000,
    PH_ERR        = 11'b10000000000
  } phase_t;

  localparam logic [1:0] ST_MORE  = 2'd0;
  localparam logic [1:0] ST_EVENT = 2'd1;
  localparam logic [1:0] ST_CHUNK = 2'd2;
  localparam logic [1:0] ST_ERROR = 2'd3;

  localparam logic [1:0] KIND_CHANNEL = 2'd0;
  localparam logic [1:0] KIND_META    = 2'd1;
  localparam logic [1:0] KIND_SYSEX   = 2'd2;

  localparam logic [7:0] BYTE_META   = 8'hFF;
  localparam logic [7:0] BYTE_SYSEX  = 8'hF0;
  localparam logic [7:0] BYTE_ESCAPE = 8'hF7;

  // Data bytes that follow a channel status; zero when it is not one.
  function automatic logic [1:0] channel_count(input logic [7:0] s);
    logic [1:0] n;
    n = 2'd0;
    case (s[7:4])
      4'hC, 4'hD: n = 2'd1;
      4'h8, 4'h9, 4'hA, 4'hB, 4'hE: n = 2'd2;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

// ----- hdl/mtcp_outq.sv -----
// Two-entry output queue for the parser's result items.
// Depends on mtcp_pkg.
module mtcp_outq import mtcp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_one,
  input  logic      push_two,
  input  out_item_t item_a,
  input  out_item_t item_b,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  out_item_t  slot [2];
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign out_item  = slot[0];
  // Room for two new results once the head entry leaves.
  assign room      = (count == 2'd0) || ((count == 2'd1) && pop);

  // Shift and fill the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      if (push_two) begin
        slot[0] <= item_a;
        slot[1] <= item_b;
        count   <= 2'd2;
      end else if (push_one) begin
        slot[0] <= item_a;
        count   <= 2'd1;
      end else if (pop) begin
        slot[0] <= slot[1];
        count   <= count - 2'd1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push_one || push_two) |-> room) else $error("push without room");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");
  a_single_push: assert property (@(posedge clk) disable iff (rst)
    !(push_one && push_two)) else $error("two push kinds at once");

endmodule

// ----- hdl/midi_track_chunk_parser.sv -----
// Top level of the MIDI track chunk parser: event decoder and output queue.
// Depends on mtcp_pkg and mtcp_outq.
//
// Takes one track chunk byte per cycle while in_ready is high, starting with the
// four-byte length, and gives one result per byte (two for a data byte under
// running status, the stored status byte first). A byte is decoded by the phase
// register and a short next-state path; results wait in a two-entry queue, so
// bytes flow at one per cycle while the consumer keeps up, and running status holds
// off input while its extra result drains. Error holds until a byte with restart.
module midi_track_chunk_parser import mtcp_pkg::*; #(
  parameter int VARLEN_MAX_BYTES = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  phase_t      phase, phase_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [31:0] chunk_bytes_seen, chunk_bytes_seen_next;
  logic [27:0] varlen_accum, varlen_accum_next;
  logic [2:0]  varlen_count, varlen_count_next;
  logic [27:0] delta_value, delta_value_next;
  logic [7:0]  running_status_byte, running_status_byte_next;
  logic [1:0]  data_bytes_left, data_bytes_left_next;
  logic [27:0] payload_left, payload_left_next;
  logic [1:0]  kind_reg, kind_reg_next;

  logic       room, take;
  logic       fail, complete, emit, pre, at_end, vl_done, vl_long;
  logic [7:0] b;
  logic [1:0] cnt, st;
  logic [2:0] vl_count;
  logic [27:0] vl_accum;
  out_item_t  item_a, item_b;
  phase_t     ph;
  logic [31:0] seen, clen;
  logic [7:0]  rsb;

  assign in_ready = room;
  assign take     = in_valid && room;
  assign b        = in_data.in_byte;

  // Effective starting state after an optional restart.
  assign ph   = in_data.restart ? PH_LEN : phase;
  assign seen = in_data.restart ? 32'd0 : chunk_bytes_seen;
  assign clen = in_data.restart ? 32'd0 : chunk_length;
  assign rsb  = in_data.restart ? 8'd0 : running_status_byte;

  // Variable-length quantity step.
  always_comb begin
    vl_count = (in_data.restart ? 3'd0 : varlen_count) + 3'd1;
    vl_long  = ({29'd0, vl_count} > 32'(VARLEN_MAX_BYTES));
    vl_accum = {varlen_accum[20:0] & {21{!in_data.restart}}, b[6:0]};
    vl_done  = !vl_long && !b[7];
  end

  // Next-state decode for one byte.
  always_comb begin
    phase_next               = ph;
    chunk_length_next        = clen;
    chunk_bytes_seen_next    = seen;
    varlen_accum_next        = in_data.restart ? 28'd0 : varlen_accum;
    varlen_count_next        = in_data.restart ? 3'd0 : varlen_count;
    delta_value_next         = in_data.restart ? 28'd0 : delta_value;
    running_status_byte_next = rsb;
    data_bytes_left_next     = in_data.restart ? 2'd0 : data_bytes_left;
    payload_left_next        = in_data.restart ? 28'd0 : payload_left;
    kind_reg_next            = in_data.restart ? KIND_CHANNEL : kind_reg;
    fail = 1'b0; complete = 1'b0; emit = 1'b0; pre = 1'b0; at_end = 1'b0;
    cnt  = 2'd0;
    st   = ST_MORE;
    if (ph == PH_ERR || ph == PH_DONE) begin
      fail = 1'b1;
    end else if (ph == PH_LEN) begin
      chunk_length_next = {clen[23:0], b};
      if (seen >= 32'd3) begin
        chunk_bytes_seen_next = 32'd0;
        phase_next            = PH_DELTA;
        varlen_accum_next     = 28'd0;
        varlen_count_next     = 3'd0;
      end else begin
        chunk_bytes_seen_next = seen + 32'd1;
      end
    end else if (seen >= clen) begin
      fail = 1'b1;
    end else begin
      chunk_bytes_seen_next = seen + 32'd1;
      at_end = (seen + 32'd1 == clen);
      case (ph)
        PH_DELTA: begin
          varlen_count_next = vl_count;
          if (vl_long) begin
            fail = 1'b1;
          end else begin
            varlen_accum_next = vl_accum;
            if (vl_done) begin
              delta_value_next = vl_accum;
              phase_next       = PH_TYPE;
            end
          end
        end
        PH_TYPE: begin
          if (b == BYTE_META) begin
            kind_reg_next = KIND_META;
            emit = 1'b1;
            phase_next = PH_META_TYPE;
          end else if (b == BYTE_SYSEX || b == BYTE_ESCAPE) begin
            kind_reg_next = KIND_SYSEX;
            emit = 1'b1;
            varlen_accum_next = 28'd0;
            varlen_count_next = 3'd0;
            phase_next = PH_SYSEX_LEN;
          end else begin
            kind_reg_next = KIND_CHANNEL;
            if (b[7]) begin
              running_status_byte_next = b;
              cnt = channel_count(b);
              if (cnt == 2'd0) begin
                fail = 1'b1;
              end else begin
                emit = 1'b1;
                data_bytes_left_next = cnt;
                phase_next = PH_CHAN;
              end
            end else begin
              cnt = channel_count(rsb);
              if (cnt == 2'd0) begin
                fail = 1'b1;
              end else begin
                pre  = 1'b1;
                emit = 1'b1;
                data_bytes_left_next = cnt - 2'd1;
                if (cnt == 2'd1) complete = 1'b1;
                else phase_next = PH_CHAN;
              end
            end
          end
        end
        PH_CHAN: begin
          emit = 1'b1;
          data_bytes_left_next = data_bytes_left - 2'd1;
          if (data_bytes_left == 2'd1) complete = 1'b1;
        end
        PH_META_TYPE: begin
          emit = 1'b1;
          varlen_accum_next = 28'd0;
          varlen_count_next = 3'd0;
          phase_next = PH_META_LEN;
        end
        PH_META_LEN, PH_SYSEX_LEN: begin
          varlen_count_next = vl_count;
          if (vl_long) begin
            fail = 1'b1;
          end else begin
            varlen_accum_next = vl_accum;
            emit = (ph == PH_META_LEN);
            if (vl_done) begin
              payload_left_next = vl_accum;
              if (vl_accum == 28'd0) complete = 1'b1;
              else phase_next = (ph == PH_META_LEN) ? PH_META_DATA : PH_SYSEX_DATA;
            end
          end
        end
        PH_META_DATA, PH_SYSEX_DATA: begin
          if (ph == PH_SYSEX_DATA && b[7] && b != BYTE_ESCAPE) begin
            fail = 1'b1;
          end else begin
            emit = 1'b1;
            payload_left_next = payload_left - 28'd1;
            if (payload_left == 28'd1) complete = 1'b1;
          end
        end
        default: fail = 1'b1;
      endcase
      if (at_end && !complete) fail = 1'b1;
    end
    if (fail) begin
      phase_next = PH_ERR;
      pre  = 1'b0;
      emit = 1'b0;
      st   = ST_ERROR;
    end else if (complete) begin
      phase_next = at_end ? PH_DONE : PH_DELTA;
      varlen_accum_next = 28'd0;
      varlen_count_next = 3'd0;
      st = at_end ? ST_CHUNK : ST_EVENT;
    end
  end

  // Result items: the stored status byte first under running status.
  always_comb begin
    item_a.status         = ST_MORE;
    item_a.out_byte       = running_status_byte_next;
    item_a.out_byte_valid = 1'b1;
    item_a.event_kind     = kind_reg_next;
    item_a.delta_ticks    = delta_value_next;
    item_a.last           = 1'b0;
    item_b.status         = st;
    item_b.out_byte       = emit ? b : 8'd0;
    item_b.out_byte_valid = emit;
    item_b.event_kind     = kind_reg_next;
    item_b.delta_ticks    = delta_value_next;
    item_b.last           = 1'b1;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_LEN;
      chunk_length        <= 32'd0;
      chunk_bytes_seen    <= 32'd0;
      varlen_accum        <= 28'd0;
      varlen_count        <= 3'd0;
      delta_value         <= 28'd0;
      running_status_byte <= 8'd0;
      data_bytes_left     <= 2'd0;
      payload_left        <= 28'd0;
      kind_reg            <= KIND_CHANNEL;
    end else if (take) begin
      phase               <= phase_next;
      chunk_length        <= chunk_length_next;
      chunk_bytes_seen    <= chunk_bytes_seen_next;
      varlen_accum        <= varlen_accum_next;
      varlen_count        <= varlen_count_next;
      delta_value         <= delta_value_next;
      running_status_byte <= running_status_byte_next;
      data_bytes_left     <= data_bytes_left_next;
      payload_left        <= payload_left_next;
      kind_reg            <= kind_reg_next;
    end
  end

  mtcp_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push_one  (take && !pre),
    .push_two  (take && pre),
    .item_a    (pre ? item_a : item_b),
    .item_b    (item_b),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_data)
  );

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ERR && !(take && in_data.restart)) |=> phase == PH_ERR)
    else $error("error state left without restart");
  // An overlong quantity leaves the count one past the limit, but only in error.
  a_vl_bound: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_ERR) |-> ({29'd0, varlen_count} <= 32'(VARLEN_MAX_BYTES)))
    else $error("variable length count past limit");
  a_done_next: assert property (@(posedge clk) disable iff (rst)
    (take && phase == PH_DONE && !in_data.restart) |=> phase == PH_ERR)
    else $error("byte after chunk end not flagged");

endmodule
